/* hw/rtl/ttb_pkg.sv */
// shared types and constants for the triangle tangent and binormal block
`timescale 1ns / 1ps
`default_nettype none
package ttb_pkg;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HOLD,
    OP_THIRD,
    OP_MUL,
    OP_VLOAD,
    OP_ZERO,
    OP_SHR,
    OP_SHL,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
    logic       vsel;
  } cmd_t;

  typedef struct packed {
    logic big_zero;
    logic big_hi;
    logic big_lo;
    logic out_busy;
  } status_t;

  // 0.0001 in q32.32, negated
  localparam logic signed [63:0] DET_LIMIT = -64'sd429497;
  localparam logic [16:0] Q_MAX = 17'd32767;
  localparam int unsigned NUM_PROD = 14;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS = 17;

endpackage
`default_nettype wire

/* hw/rtl/ttb_in_if.sv */
// corner word channel
`timescale 1ns / 1ps
`default_nettype none
interface ttb_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;

  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  input ready);
  modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                output ready);
endinterface
`default_nettype wire

/* hw/rtl/ttb_out_if.sv */
// result word channel
`timescale 1ns / 1ps
`default_nettype none
interface ttb_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] first_index;
  logic        [31:0] second_index;
  logic        [31:0] third_index;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [15:0] binormal_x;
  logic signed [15:0] binormal_y;
  logic signed [15:0] binormal_z;
  logic               tangent_degenerate;
  logic               binormal_degenerate;

  modport source (output valid, first_index, second_index, third_index,
                  tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z,
                  tangent_degenerate, binormal_degenerate,
                  input ready);
  modport sink (input valid, first_index, second_index, third_index,
                tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z,
                tangent_degenerate, binormal_degenerate,
                output ready);
endinterface
`default_nettype wire

/* hw/rtl/ttb_ctrl.sv */
// sequencer for corner collection, products, normalize, square root and divide
`timescale 1ns / 1ps
`default_nettype none
module ttb_ctrl
  import ttb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_VLOAD = 8'b0000_0100,
    S_NORM  = 8'b0000_1000,
    S_SQ    = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] ccount, ccount_next;
  logic [1:0] comp, comp_next;
  logic       vsel, vsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      ccount <= '0;
      comp   <= '0;
      vsel   <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      ccount <= ccount_next;
      comp   <= comp_next;
      vsel   <= vsel_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ccount_next = ccount;
    comp_next   = comp;
    vsel_next   = vsel;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.idx     = '0;
    cmd.vsel    = vsel;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (ccount == 2'd2) begin
            cmd.op      = OP_THIRD;
            ccount_next = '0;
            cnt_next    = '0;
            vsel_next   = 1'b0;
            state_next  = S_MUL;
          end else begin
            cmd.op      = OP_HOLD;
            cmd.idx     = {3'b000, ccount[0]};
            ccount_next = ccount + 2'd1;
          end
        end
      end
      S_MUL: begin
        // a pass with no product issued lets the last product settle into its difference
        if (cnt < 5'(NUM_PROD)) begin
          cmd.op   = OP_MUL;
          cmd.idx  = cnt[3:0];
          cnt_next = cnt + 5'd1;
        end else begin
          state_next = S_VLOAD;
        end
      end
      S_VLOAD: begin
        cmd.op     = OP_VLOAD;
        state_next = S_NORM;
      end
      S_NORM: begin
        priority if (status.big_zero) begin
          cmd.op = OP_ZERO;
          if (!vsel) begin
            vsel_next  = 1'b1;
            state_next = S_VLOAD;
          end else begin
            state_next = S_DONE;
          end
        end else if (status.big_hi) begin
          cmd.op = OP_SHR;
        end else if (status.big_lo) begin
          cmd.op = OP_SHL;
        end else begin
          cnt_next   = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (cnt < 5'd3) begin
          cmd.op   = OP_SQ;
          cmd.idx  = cnt[3:0];
          cnt_next = cnt + 5'd1;
        end else if (cnt == 5'd3) begin
          cnt_next = cnt + 5'd1;
        end else begin
          cmd.op     = OP_SQRT_INIT;
          cnt_next   = '0;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          cnt_next   = '0;
          comp_next  = '0;
          state_next = S_DIV;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DIV: begin
        cmd.idx = {2'b00, comp};
        if (cnt == 5'd0) begin
          cmd.op   = OP_DIV_INIT;
          cnt_next = cnt + 5'd1;
        end else if (cnt <= 5'(DIV_STEPS)) begin
          cmd.op   = OP_DIV_STEP;
          cnt_next = cnt + 5'd1;
        end else begin
          cmd.op   = OP_DIV_STORE;
          cnt_next = '0;
          if (comp == 2'd2) begin
            if (!vsel) begin
              vsel_next  = 1'b1;
              state_next = S_VLOAD;
            end else begin
              state_next = S_DONE;
            end
          end else begin
            comp_next = comp + 2'd1;
          end
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/ttb_datapath.sv */
// corner store, shared multiplier, normalizer, square root, divider, output register
`timescale 1ns / 1ps
`default_nettype none
module ttb_datapath
  import ttb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic        [31:0] vertex_index,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] tex_u,
  input  wire logic signed [31:0] tex_v,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic             [31:0] first_index,
  output logic             [31:0] second_index,
  output logic             [31:0] third_index,
  output logic signed      [15:0] tangent_x,
  output logic signed      [15:0] tangent_y,
  output logic signed      [15:0] tangent_z,
  output logic signed      [15:0] binormal_x,
  output logic signed      [15:0] binormal_y,
  output logic signed      [15:0] binormal_z,
  output logic                    tangent_degenerate,
  output logic                    binormal_degenerate
);

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return d[31:0];
  endfunction

  // corners zero and one
  logic signed [31:0] hpos [2][3];
  logic signed [31:0] htex [2][2];
  logic        [31:0] hidx [2];
  logic        [31:0] idx2;

  logic signed [31:0] e1 [3];
  logic signed [31:0] e2 [3];
  logic signed [31:0] d1u, d1v, d2u, d2v;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               prod_live;
  logic               prod_sq;
  logic        [3:0]  prod_step;
  logic signed [63:0] acc;
  logic signed [63:0] det;
  logic signed [63:0] tanv [3];
  logic signed [63:0] binv [3];
  logic               flip;

  logic        [63:0] m [3];
  logic               neg [3];
  logic        [63:0] big, big01;
  logic signed [63:0] src [3];
  logic        [61:0] sumsq;

  logic        [63:0] sq_s, sq_res, sq_bit, sq_trial;
  logic        [31:0] r;

  logic        [45:0] num;
  logic        [31:0] dv_rem, dv_t;
  logic        [16:0] dv_nb, dv_q, qc;
  logic        [15:0] qval;

  logic signed [15:0] tan_o [3];
  logic signed [15:0] bin_o [3];
  logic               deg [2];

  // corner capture and edge/delta formation
  always_ff @(posedge clk) begin
    if (cmd.op == OP_HOLD) begin
      hidx[cmd.idx[0]]    <= vertex_index;
      hpos[cmd.idx[0]][0] <= pos_x;
      hpos[cmd.idx[0]][1] <= pos_y;
      hpos[cmd.idx[0]][2] <= pos_z;
      htex[cmd.idx[0]][0] <= tex_u;
      htex[cmd.idx[0]][1] <= tex_v;
    end
    if (cmd.op == OP_THIRD) begin
      idx2  <= vertex_index;
      e1[0] <= sat_sub(hpos[1][0], hpos[0][0]);
      e1[1] <= sat_sub(hpos[1][1], hpos[0][1]);
      e1[2] <= sat_sub(hpos[1][2], hpos[0][2]);
      e2[0] <= sat_sub(pos_x, hpos[0][0]);
      e2[1] <= sat_sub(pos_y, hpos[0][1]);
      e2[2] <= sat_sub(pos_z, hpos[0][2]);
      d1u   <= sat_sub(htex[1][0], htex[0][0]);
      d1v   <= sat_sub(htex[1][1], htex[0][1]);
      d2u   <= sat_sub(tex_u, htex[0][0]);
      d2v   <= sat_sub(tex_v, htex[0][1]);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = d1u;
    mul_b = d2v;
    if (cmd.op == OP_SQ) begin
      unique case (cmd.idx[1:0])
        2'd0:    mul_a = signed'(m[0][31:0]);
        2'd1:    mul_a = signed'(m[1][31:0]);
        default: mul_a = signed'(m[2][31:0]);
      endcase
      mul_b = mul_a;
    end else begin
      unique case (cmd.idx)
        4'd0:    begin mul_a = d1u; mul_b = d2v;   end
        4'd1:    begin mul_a = d2u; mul_b = d1v;   end
        4'd2:    begin mul_a = d2v; mul_b = e1[0]; end
        4'd3:    begin mul_a = d1v; mul_b = e2[0]; end
        4'd4:    begin mul_a = d2v; mul_b = e1[1]; end
        4'd5:    begin mul_a = d1v; mul_b = e2[1]; end
        4'd6:    begin mul_a = d2v; mul_b = e1[2]; end
        4'd7:    begin mul_a = d1v; mul_b = e2[2]; end
        4'd8:    begin mul_a = d1u; mul_b = e2[0]; end
        4'd9:    begin mul_a = d2u; mul_b = e1[0]; end
        4'd10:   begin mul_a = d1u; mul_b = e2[1]; end
        4'd11:   begin mul_a = d2u; mul_b = e1[1]; end
        4'd12:   begin mul_a = d1u; mul_b = e2[2]; end
        default: begin mul_a = d2u; mul_b = e1[2]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_live <= 1'b0;
    end else begin
      prod_live <= (cmd.op == OP_MUL) || (cmd.op == OP_SQ);
    end
  end

  always_ff @(posedge clk) begin
    prod      <= mul_a * mul_b;
    prod_sq   <= (cmd.op == OP_SQ);
    prod_step <= cmd.idx;
    if (prod_live) begin
      if (prod_sq) begin
        sumsq <= (prod_step == 4'd0) ? prod[61:0] : sumsq + prod[61:0];
      end else if (!prod_step[0]) begin
        acc <= prod;
      end else begin
        unique case (prod_step[3:1])
          3'd0:    det     <= acc - prod;
          3'd1:    tanv[0] <= acc - prod;
          3'd2:    tanv[1] <= acc - prod;
          3'd3:    tanv[2] <= acc - prod;
          3'd4:    binv[0] <= acc - prod;
          3'd5:    binv[1] <= acc - prod;
          default: binv[2] <= acc - prod;
        endcase
      end
    end
  end

  assign flip = det < DET_LIMIT;

  // magnitudes and range normalize
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src[i] = cmd.vsel ? binv[i] : tanv[i];
    end
    big01 = (m[0] > m[1]) ? m[0] : m[1];
    big   = (big01 > m[2]) ? big01 : m[2];
  end

  assign status.big_zero = (big == 64'd0);
  assign status.big_hi   = |big[63:30];
  assign status.big_lo   = ~|big[63:29];
  assign status.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_VLOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= src[i][63];
          m[i]   <= src[i][63] ? 64'(-src[i]) : 64'(src[i]);
        end
      end
      OP_SHR: begin
        for (int i = 0; i < 3; i++) begin
          m[i] <= m[i] >> 1;
        end
      end
      OP_SHL: begin
        for (int i = 0; i < 3; i++) begin
          m[i] <= m[i] << 1;
        end
      end
      default: begin
      end
    endcase
  end

  // bit-serial square root, one result bit per cycle
  assign sq_trial = sq_res + sq_bit;
  assign r        = sq_res[31:0];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT_INIT) begin
      sq_s   <= {2'b00, sumsq};
      sq_res <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
    end else if (cmd.op == OP_SQRT_STEP) begin
      if (sq_s >= sq_trial) begin
        sq_s   <= sq_s - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // restoring divider, numerator top part always below the divisor
  always_comb begin
    unique case (cmd.idx[1:0])
      2'd0:    num = {1'b0, m[0][29:0], 15'b0};
      2'd1:    num = {1'b0, m[1][29:0], 15'b0};
      default: num = {1'b0, m[2][29:0], 15'b0};
    endcase
    num  = num + {15'b0, r[31:1]};
    dv_t = {dv_rem[30:0], dv_nb[16]};
    qc   = (dv_q > Q_MAX) ? Q_MAX : dv_q;
    qval = (neg[cmd.idx[1:0]] != flip) ? 16'(-qc) : qc[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_INIT) begin
      dv_rem <= {3'b000, num[45:17]};
      dv_nb  <= num[16:0];
      dv_q   <= '0;
    end else if (cmd.op == OP_DIV_STEP) begin
      if (dv_t >= r) begin
        dv_rem <= dv_t - r;
        dv_q   <= {dv_q[15:0], 1'b1};
      end else begin
        dv_rem <= dv_t;
        dv_q   <= {dv_q[15:0], 1'b0};
      end
      dv_nb <= dv_nb << 1;
    end
  end

  // finished components
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_VLOAD: begin
        deg[cmd.vsel] <= 1'b0;
      end
      OP_ZERO: begin
        deg[cmd.vsel] <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (cmd.vsel) begin
            bin_o[i] <= '0;
          end else begin
            tan_o[i] <= '0;
          end
        end
      end
      OP_DIV_STORE: begin
        if (cmd.vsel) begin
          bin_o[cmd.idx[1:0]] <= signed'(qval);
        end else begin
          tan_o[cmd.idx[1:0]] <= signed'(qval);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      first_index         <= hidx[0];
      second_index        <= hidx[1];
      third_index         <= idx2;
      tangent_x           <= tan_o[0];
      tangent_y           <= tan_o[1];
      tangent_z           <= tan_o[2];
      binormal_x          <= bin_o[0];
      binormal_y          <= bin_o[1];
      binormal_z          <= bin_o[2];
      tangent_degenerate  <= deg[0];
      binormal_degenerate <= deg[1];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/triangle_tangent_binormal.sv */
// Per-triangle tangent and binormal unit.
// corner: one word per triangle corner (vertex index, q16.16 position and texture
//   coordinate). corners zero and one are held; the third starts the computation.
// result: one word per whole triangle with the three indices, the q1.15 unit
//   tangent and binormal, and a flag for each vector that came out zero.
// After the third corner the block is busy: first the products on the one
//   shared 32x32 multiplier, then per vector a load, single-bit normalize
//   shifts and a range check, the squares, the bit-serial square root and
//   three 17-step divides; a zero vector takes only the load and the check.
//   Finally the output register is written.
// No corner is taken while a triangle is in work; the result sits in an output
//   register, so the next two corners are taken while it waits.
// A stalled receiver only holds the result; a finished triangle waits for the
//   output register to empty before it is written.
// Reset (rst, synchronous) drops any partial triangle and the pending result.
// Corners that never complete a triangle produce no result.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_binormal
  import ttb_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  ttb_in_if.sink   corner,
  ttb_out_if.source result
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign corner.ready = in_ready;

  ttb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (corner.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttb_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .vertex_index        (corner.vertex_index),
    .pos_x               (corner.pos_x),
    .pos_y               (corner.pos_y),
    .pos_z               (corner.pos_z),
    .tex_u               (corner.tex_u),
    .tex_v               (corner.tex_v),
    .out_ready           (result.ready),
    .out_valid           (result.valid),
    .first_index         (result.first_index),
    .second_index        (result.second_index),
    .third_index         (result.third_index),
    .tangent_x           (result.tangent_x),
    .tangent_y           (result.tangent_y),
    .tangent_z           (result.tangent_z),
    .binormal_x          (result.binormal_x),
    .binormal_y          (result.binormal_y),
    .binormal_z          (result.binormal_z),
    .tangent_degenerate  (result.tangent_degenerate),
    .binormal_degenerate (result.binormal_degenerate)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the triangle tangent and binormal block
`timescale 1ns / 1ps
module testbench;
  import ttb_pkg::*;

  typedef struct packed {
    logic [31:0] vertex_index;
    logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  } corner_t;

  typedef struct packed {
    logic [31:0] first_index, second_index, third_index;
    logic [15:0] tangent_x, tangent_y, tangent_z;
    logic [15:0] binormal_x, binormal_y, binormal_z;
    logic        tangent_degenerate, binormal_degenerate;
  } frame_t;

  logic clk = 0;
  logic rst = 1;
  always #6 clk = ~clk;

  ttb_in_if corner_ch ();
  ttb_out_if result_ch ();

  triangle_tangent_binormal dut (
    .clk(clk), .rst(rst), .corner(corner_ch.sink), .result(result_ch.source)
  );

  corner_t pending_corners[$];
  frame_t  expected_frames[$];
  int      errors = 0;
  bit      calm = 0;
  bit      hold_off = 0;
  bit      stim_done = 0;

  // predictor state
  int      held_count = 0;
  corner_t held_c0, held_c1;

  task automatic add_corner(corner_t c);
    pending_corners.insert(pending_corners.size(), c);
  endtask

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic unit_q15(input logic signed [63:0] v[3], input bit flip,
                                    output logic [15:0] o[3]);
    logic [63:0] m[3];
    logic [63:0] big, sum, r, q;
    bit neg[3];
    big = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1;
    end
    while (big >= (64'd1 << 30)) begin
      big = big >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (big < (64'd1 << 29)) begin
      big = big << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    r = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd32768 + (r >> 1)) / r;
      if (q > 64'd32767) q = 64'd32767;
      o[i] = (neg[i] != flip) ? -q[15:0] : q[15:0];
    end
    return 0;
  endfunction

  function automatic logic signed [63:0] sx(logic [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  task automatic predict_corner(corner_t c);
    logic signed [63:0] e1[3], e2[3], tg[3], bn[3];
    logic signed [63:0] d1u, d1v, d2u, d2v, det;
    logic [31:0] p0[3], p1[3], p2[3];
    logic [15:0] to[3], bo[3];
    frame_t f;
    bit flip;
    if (held_count == 0) begin
      held_c0 = c;
      held_count = 1;
      return;
    end
    if (held_count == 1) begin
      held_c1 = c;
      held_count = 2;
      return;
    end
    p0 = '{held_c0.pos_x, held_c0.pos_y, held_c0.pos_z};
    p1 = '{held_c1.pos_x, held_c1.pos_y, held_c1.pos_z};
    p2 = '{c.pos_x, c.pos_y, c.pos_z};
    for (int i = 0; i < 3; i++) begin
      e1[i] = clamp32(sx(p1[i]) - sx(p0[i]));
      e2[i] = clamp32(sx(p2[i]) - sx(p0[i]));
    end
    d1u = clamp32(sx(held_c1.tex_u) - sx(held_c0.tex_u));
    d1v = clamp32(sx(held_c1.tex_v) - sx(held_c0.tex_v));
    d2u = clamp32(sx(c.tex_u) - sx(held_c0.tex_u));
    d2v = clamp32(sx(c.tex_v) - sx(held_c0.tex_v));
    det = d1u * d2v - d2u * d1v;
    flip = det < DET_LIMIT;
    for (int i = 0; i < 3; i++) begin
      tg[i] = d2v * e1[i] - d1v * e2[i];
      bn[i] = d1u * e2[i] - d2u * e1[i];
    end
    f.first_index = held_c0.vertex_index;
    f.second_index = held_c1.vertex_index;
    f.third_index = c.vertex_index;
    f.tangent_degenerate = unit_q15(tg, flip, to);
    f.binormal_degenerate = unit_q15(bn, flip, bo);
    f.tangent_x = to[0];
    f.tangent_y = to[1];
    f.tangent_z = to[2];
    f.binormal_x = bo[0];
    f.binormal_y = bo[1];
    f.binormal_z = bo[2];
    expected_frames.insert(expected_frames.size(), f);
    held_count = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      corner_ch.valid <= 0;
    end else begin
      if (corner_ch.valid && corner_ch.ready) begin
        predict_corner(pending_corners.pop_front());
      end
      if ((!corner_ch.valid || corner_ch.ready) ) begin
        if (pending_corners.size() > (corner_ch.valid && corner_ch.ready ? 0 : 0) &&
            !hold_off && (calm || $urandom_range(99) >= 22) &&
            !(corner_ch.valid && !corner_ch.ready)) begin
          corner_ch.valid <= 1;
          {corner_ch.vertex_index, corner_ch.pos_x, corner_ch.pos_y, corner_ch.pos_z,
           corner_ch.tex_u, corner_ch.tex_v} <= pending_corners[0];
        end else begin
          corner_ch.valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_t g, w;
    if (rst) begin
      result_ch.ready <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        g = {result_ch.first_index, result_ch.second_index, result_ch.third_index,
             result_ch.tangent_x, result_ch.tangent_y, result_ch.tangent_z,
             result_ch.binormal_x, result_ch.binormal_y, result_ch.binormal_z,
             result_ch.tangent_degenerate, result_ch.binormal_degenerate};
        if (expected_frames.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          w = expected_frames.pop_front();
          if (g.first_index !== w.first_index) begin
            $error("first_index exp %h got %h", w.first_index, g.first_index); errors++;
          end
          if (g.second_index !== w.second_index) begin
            $error("second_index exp %h got %h", w.second_index, g.second_index); errors++;
          end
          if (g.third_index !== w.third_index) begin
            $error("third_index exp %h got %h", w.third_index, g.third_index); errors++;
          end
          if (g.tangent_x !== w.tangent_x) begin
            $error("tangent_x exp %h got %h", w.tangent_x, g.tangent_x); errors++;
          end
          if (g.tangent_y !== w.tangent_y) begin
            $error("tangent_y exp %h got %h", w.tangent_y, g.tangent_y); errors++;
          end
          if (g.tangent_z !== w.tangent_z) begin
            $error("tangent_z exp %h got %h", w.tangent_z, g.tangent_z); errors++;
          end
          if (g.binormal_x !== w.binormal_x) begin
            $error("binormal_x exp %h got %h", w.binormal_x, g.binormal_x); errors++;
          end
          if (g.binormal_y !== w.binormal_y) begin
            $error("binormal_y exp %h got %h", w.binormal_y, g.binormal_y); errors++;
          end
          if (g.binormal_z !== w.binormal_z) begin
            $error("binormal_z exp %h got %h", w.binormal_z, g.binormal_z); errors++;
          end
          if (g.tangent_degenerate !== w.tangent_degenerate) begin
            $error("tangent_degenerate exp %b got %b", w.tangent_degenerate,
                   g.tangent_degenerate); errors++;
          end
          if (g.binormal_degenerate !== w.binormal_degenerate) begin
            $error("binormal_degenerate exp %b got %b", w.binormal_degenerate,
                   g.binormal_degenerate); errors++;
          end
        end
      end
      result_ch.ready <= calm || $urandom_range(99) >= 22;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(1) ? 32'd0 : 32'hffffffff;
      default: return $urandom_range(131072) - 65536;
    endcase
  endfunction

  function automatic corner_t rand_corner();
    corner_t c;
    c.vertex_index = $urandom;
    c.pos_x = rand_coord();
    c.pos_y = rand_coord();
    c.pos_z = rand_coord();
    c.tex_u = rand_coord();
    c.tex_v = rand_coord();
    return c;
  endfunction

  function automatic corner_t mk(logic [31:0] i, x, y, z, u, v);
    return {i, x, y, z, u, v};
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MX = 32'h7fff_ffff;
  localparam logic [31:0] MN = 32'h8000_0000;

  initial begin
    corner_ch.valid = 0;
    corner_ch.vertex_index = 0;
    corner_ch.pos_x = 0;
    corner_ch.pos_y = 0;
    corner_ch.pos_z = 0;
    corner_ch.tex_u = 0;
    corner_ch.tex_v = 0;
    result_ch.ready = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    // unit right triangle, positive determinant
    add_corner(mk(0, 0, 0, 0, 0, 0));
    add_corner(mk(1, ONE, 0, 0, ONE, 0));
    add_corner(mk(2, 0, ONE, 0, 0, ONE));
    // mirrored uv gives a negative determinant and a flip
    add_corner(mk(3, 0, 0, 0, 0, 0));
    add_corner(mk(4, ONE, 0, 0, 0, ONE));
    add_corner(mk(5, 0, ONE, 0, ONE, 0));
    // all corners equal: both vectors zero
    add_corner(mk(6, ONE, ONE, ONE, ONE, ONE));
    add_corner(mk(7, ONE, ONE, ONE, ONE, ONE));
    add_corner(mk(32'hffffffff, ONE, ONE, ONE, ONE, ONE));
    // extremes, saturating edges and deltas
    add_corner(mk(32'hffffffff, MN, MN, MN, MN, MN));
    add_corner(mk(0, MX, MX, MN, MX, MN));
    add_corner(mk(32'h80000000, MX, MN, MX, MN, MX));
    // collinear uv: determinant zero
    add_corner(mk(9, 0, 0, 0, 0, 0));
    add_corner(mk(10, ONE, 0, ONE, ONE, ONE));
    add_corner(mk(11, 0, ONE, 0, 2 * ONE, 2 * ONE));
    // tiny negative determinant, above the limit, so no flip
    add_corner(mk(12, 0, 0, 0, 0, 0));
    add_corner(mk(13, ONE, 0, 0, 32'd1, 0));
    add_corner(mk(14, 0, 0, ONE, 0, 32'hffffffff));
    for (int i = 0; i < 177; i++) begin
      if (i % 20 == 7) add_corner(rand_corner());
      for (int k = 0; k < 3; k++) add_corner(rand_corner());
    end
    // pause the sender once and let everything drain
    wait (pending_corners.size() < 300);
    hold_off = 1;
    wait (expected_frames.size() == 0 && !corner_ch.valid);
    repeat (300) @(posedge clk);
    hold_off = 0;
    calm = 1;
    wait (pending_corners.size() < 150);
    calm = 0;
    wait (pending_corners.size() == 0);
    @(posedge clk);
    wait (expected_frames.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
